### design/lwe_pkg.sv
// Shared widths, codes and reset values for the LSB watermark embedder.
`timescale 1ns / 1ps
`default_nettype none
package lwe_pkg;

  localparam int unsigned MAX_IMAGE_SIDE = 4096;
  localparam int unsigned MARK_DEPTH     = 4096;

  localparam int unsigned COORD_W    = $clog2(MAX_IMAGE_SIDE);
  localparam int unsigned DIM_W      = COORD_W + 1;
  localparam int unsigned MSIZE_W    = 7;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned MARK_AW    = $clog2(MARK_DEPTH);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam int unsigned QUOT_W       = MSIZE_W;
  localparam int unsigned REM_W        = COORD_W + MSIZE_W;
  localparam int unsigned DIV_W        = REM_W + 1;
  localparam int unsigned SCALE_STAGES = QUOT_W + 1;
  localparam int unsigned IDX_STAGE    = SCALE_STAGES;
  localparam int unsigned OUT_STAGE    = SCALE_STAGES + 1;
  localparam int unsigned PIPE_STAGES  = SCALE_STAGES + 2;
  localparam int unsigned IDX_SUM_W    = 2 * MSIZE_W + 1;

  localparam logic [COL_W-1:0] GREY_THRESHOLD = COL_W'(128);

  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = DIM_W'(480);
  localparam logic [MSIZE_W-1:0] MARK_WIDTH_RST   = MSIZE_W'(64);
  localparam logic [MSIZE_W-1:0] MARK_HEIGHT_RST  = MSIZE_W'(64);
  localparam logic [COORD_W-1:0] ROW_FIRST_RST    = '0;
  localparam logic [DIM_W-1:0]   ROW_END_RST      = DIM_W'(MAX_IMAGE_SIDE);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_MARK_WIDTH   = 3'd2,
    CFG_MARK_HEIGHT  = 3'd3,
    CFG_ROW_FIRST    = 3'd4,
    CFG_ROW_END      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [MARK_AW-1:0] addr;
    logic               wdata;
  } ram_req_t;

endpackage
`default_nettype wire

### design/lwe_mark_ram.sv
// Single-port watermark bit store with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module lwe_mark_ram
  import lwe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire ram_req_t req_i,
  output logic          rdata_o
);

  logic mem_q [MARK_DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/lwe_scale.sv
// Pipelined nearest-neighbour scaler: coord * mark_size / image_size.
`timescale 1ns / 1ps
`default_nettype none
module lwe_scale
  import lwe_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic [SCALE_STAGES-1:0] adv_i,
  input  wire logic [COORD_W-1:0]      coord_i,
  input  wire logic [MSIZE_W-1:0]      mark_size_i,
  input  wire logic [DIM_W-1:0]        image_size_i,
  output logic      [QUOT_W-1:0]       quot_o
);

  logic [REM_W-1:0]  rem_q  [SCALE_STAGES];
  logic [QUOT_W-1:0] quot_q [SCALE_STAGES];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      rem_q[0]  <= REM_W'(coord_i) * REM_W'(mark_size_i);
      quot_q[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s < SCALE_STAGES; s++) begin : g_step
    logic [DIV_W-1:0] dvs;
    logic             fit;

    assign dvs = DIV_W'(image_size_i) << (QUOT_W - s);
    assign fit = {1'b0, rem_q[s-1]} >= dvs;

    always_ff @(posedge clk_i) begin
      if (adv_i[s]) begin
        rem_q[s]  <= fit ? rem_q[s-1] - dvs[REM_W-1:0] : rem_q[s-1];
        quot_q[s] <= quot_q[s-1] | (QUOT_W'(fit) << (QUOT_W - s));
      end
    end
  end

  assign quot_o = quot_q[SCALE_STAGES-1];

endmodule
`default_nettype wire

### design/lsb_watermark_embed.sv
// Top level of the LSB watermark embedder: config, pipeline control and output.
//
//   channel   direction  handshake                 payload
//   in        to block   in_valid_i / in_stall_o   command, mark_value, pixel_x/y, rgb in
//   out       from block out_valid_o / out_stall_i rgb out, was_marked, embedded_bit
//   cfg       to block   cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One word is accepted per cycle while in_stall_o is low; a pixel word reaches the output
// after seven divider steps, the index stage and the mark RAM read, which follow the
// multiply stage that takes the word.
// Load words write the RAM in the same stage that pixels read it and give no output.
// Reset restores the register defaults and empties the pipeline; the store is not cleared.
// A stalled output holds; bubbles in the pipeline still fill while it waits.
`timescale 1ns / 1ps
`default_nettype none
module lsb_watermark_embed
  import lwe_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  command_i,
  input  wire logic [COL_W-1:0]      mark_value_i,
  input  wire logic [COORD_W-1:0]    pixel_x_i,
  input  wire logic [COORD_W-1:0]    pixel_y_i,
  input  wire logic [COL_W-1:0]      red_in_i,
  input  wire logic [COL_W-1:0]      green_in_i,
  input  wire logic [COL_W-1:0]      blue_in_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COL_W-1:0]      red_out_o,
  output logic      [COL_W-1:0]      green_out_o,
  output logic      [COL_W-1:0]      blue_out_o,
  output logic                       was_marked_o,
  output logic                       embedded_bit_o
);

  typedef struct packed {
    cmd_e             cmd;
    logic             mark_bit;
    logic             in_range;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } side_t;

  logic [DIM_W-1:0]   image_width_q;
  logic [DIM_W-1:0]   image_height_q;
  logic [MSIZE_W-1:0] mark_width_q;
  logic [MSIZE_W-1:0] mark_height_q;
  logic [COORD_W-1:0] row_first_q;
  logic [DIM_W-1:0]   row_end_q;

  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] en;
  side_t                  side_q [PIPE_STAGES];
  side_t                  side_d;

  logic [QUOT_W-1:0]  quot_x;
  logic [QUOT_W-1:0]  quot_y;
  logic [IDX_SUM_W-1:0] idx_sum;
  logic [MARK_AW-1:0] idx_q;
  logic [MARK_AW-1:0] load_addr_q;
  ram_req_t           ram_req;
  logic               ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      image_height_q <= IMAGE_HEIGHT_RST;
      mark_width_q   <= MARK_WIDTH_RST;
      mark_height_q  <= MARK_HEIGHT_RST;
      row_first_q    <= ROW_FIRST_RST;
      row_end_q      <= ROW_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i;
        CFG_MARK_WIDTH:   mark_width_q   <= cfg_wdata_i[MSIZE_W-1:0];
        CFG_MARK_HEIGHT:  mark_height_q  <= cfg_wdata_i[MSIZE_W-1:0];
        CFG_ROW_FIRST:    row_first_q    <= cfg_wdata_i[COORD_W-1:0];
        CFG_ROW_END:      row_end_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[OUT_STAGE] = !(v_q[OUT_STAGE] && side_q[OUT_STAGE].cmd == CMD_PIXEL && out_stall_i);
    for (int s = OUT_STAGE - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    side_d.cmd      = cmd_e'(command_i);
    side_d.mark_bit = mark_value_i > GREY_THRESHOLD;
    side_d.in_range = pixel_y_i >= row_first_q
                   && DIM_W'(pixel_y_i) < row_end_q
                   && DIM_W'(pixel_y_i) < image_height_q
                   && DIM_W'(pixel_x_i) < image_width_q;
    side_d.red      = red_in_i;
    side_d.green    = green_in_i;
    side_d.blue     = blue_in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < PIPE_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
    end
    for (int s = 1; s < PIPE_STAGES; s++) begin
      if (en[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  lwe_scale u_scale_x (
    .clk_i        (clk_i),
    .adv_i        (en[SCALE_STAGES-1:0]),
    .coord_i      (pixel_x_i),
    .mark_size_i  (mark_width_q),
    .image_size_i (image_width_q),
    .quot_o       (quot_x)
  );

  lwe_scale u_scale_y (
    .clk_i        (clk_i),
    .adv_i        (en[SCALE_STAGES-1:0]),
    .coord_i      (pixel_y_i),
    .mark_size_i  (mark_height_q),
    .image_size_i (image_height_q),
    .quot_o       (quot_y)
  );

  assign idx_sum = IDX_SUM_W'(quot_y) * IDX_SUM_W'(mark_width_q) + IDX_SUM_W'(quot_x);

  always_ff @(posedge clk_i) begin
    if (en[IDX_STAGE]) begin
      idx_q <= MARK_AW'(idx_sum);
    end
  end

  always_comb begin
    ram_req.en    = en[OUT_STAGE] && v_q[IDX_STAGE];
    ram_req.we    = side_q[IDX_STAGE].cmd == CMD_LOAD;
    ram_req.addr  = ram_req.we ? load_addr_q : idx_q;
    ram_req.wdata = side_q[IDX_STAGE].mark_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_addr_q <= '0;
    end else if (ram_req.en && ram_req.we) begin
      load_addr_q <= load_addr_q + MARK_AW'(1);
    end
  end

  lwe_mark_ram u_mark_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = v_q[OUT_STAGE] && side_q[OUT_STAGE].cmd == CMD_PIXEL;
  assign was_marked_o   = side_q[OUT_STAGE].in_range;
  assign embedded_bit_o = side_q[OUT_STAGE].in_range && ram_rdata;
  assign red_out_o      = was_marked_o ? {side_q[OUT_STAGE].red[COL_W-1:1], ram_rdata}
                                       : side_q[OUT_STAGE].red;
  assign green_out_o    = was_marked_o ? {side_q[OUT_STAGE].green[COL_W-1:1], ram_rdata}
                                       : side_q[OUT_STAGE].green;
  assign blue_out_o     = was_marked_o ? {side_q[OUT_STAGE].blue[COL_W-1:1], ram_rdata}
                                       : side_q[OUT_STAGE].blue;

`ifndef SYNTHESIS
  a_empty_front_takes_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> !in_stall_o)
    else $error("input stalled although the first stage is empty");

  a_load_advances_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.en && ram_req.we |=> load_addr_q == $past(load_addr_q) + MARK_AW'(1))
    else $error("load address did not advance after a store write");

  a_unmarked_has_no_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_marked_o |-> !embedded_bit_o
      && red_out_o == side_q[OUT_STAGE].red)
    else $error("unmarked pixel was modified");
`endif

endmodule
`default_nettype wire

### tb/lsb_watermark_embed_test.sv
// Self-checking testbench for the LSB watermark embedder: directed corners, random traffic, stalls.
`timescale 1ns / 1ps
module lsb_watermark_embed_test;
  import lwe_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_GAP       = 20;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_WORDS   = 120;
  localparam int unsigned MARK_FILL     = 256;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct {
    cmd_e               command;
    logic [COL_W-1:0]   mark_value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
  } embed_word_t;

  typedef struct {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             marked;
    logic             mark_bit;
  } pixel_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  command = CMD_LOAD;
  logic [COL_W-1:0]      mark_value = '0;
  logic [COORD_W-1:0]    pixel_x = '0;
  logic [COORD_W-1:0]    pixel_y = '0;
  logic [COL_W-1:0]      red_in = '0;
  logic [COL_W-1:0]      green_in = '0;
  logic [COL_W-1:0]      blue_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COL_W-1:0]      red_out;
  logic [COL_W-1:0]      green_out;
  logic [COL_W-1:0]      blue_out;
  logic                  was_marked;
  logic                  embedded_bit;

  // Predictor state: register copies, the watermark store and its load pointer.
  logic [DIM_W-1:0]   img_w = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0]   img_h = IMAGE_HEIGHT_RST;
  logic [MSIZE_W-1:0] mk_w = MARK_WIDTH_RST;
  logic [MSIZE_W-1:0] mk_h = MARK_HEIGHT_RST;
  logic [COORD_W-1:0] row_lo = ROW_FIRST_RST;
  logic [DIM_W-1:0]   row_hi = ROW_END_RST;
  logic               mark_store [MARK_DEPTH];
  logic [MARK_AW-1:0] load_ptr = '0;

  pixel_result_t expected_pixels [$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_checked = 0;
  int unsigned loads_sent = 0;
  int unsigned settings_used = 0;

  lsb_watermark_embed u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .mark_value_i   (mark_value),
    .pixel_x_i      (pixel_x),
    .pixel_y_i      (pixel_y),
    .red_in_i       (red_in),
    .green_in_i     (green_in),
    .blue_in_i      (blue_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .red_out_o      (red_out),
    .green_out_o    (green_out),
    .blue_out_o     (blue_out),
    .was_marked_o   (was_marked),
    .embedded_bit_o (embedded_bit)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void embed_predict(input embed_word_t w);
    pixel_result_t res;
    int unsigned   xu, yu, col, row, idx;
    logic          hit;
    if (w.command == CMD_LOAD) begin
      mark_store[load_ptr] = (w.mark_value > GREY_THRESHOLD);
      load_ptr = load_ptr + 1'b1;
      loads_sent++;
      return;
    end
    xu = w.x;
    yu = w.y;
    hit = (yu >= row_lo) && (yu < row_hi) && (yu < img_h) && (xu < img_w);
    res.red = w.red;
    res.green = w.green;
    res.blue = w.blue;
    res.marked = hit;
    res.mark_bit = 1'b0;
    if (hit) begin
      col = (xu * mk_w) / img_w;
      row = (yu * mk_h) / img_h;
      idx = (row * mk_w + col) % MARK_DEPTH;
      res.mark_bit = mark_store[idx];
      res.red[0] = res.mark_bit;
      res.green[0] = res.mark_bit;
      res.blue[0] = res.mark_bit;
    end
    expected_pixels.push_back(res);
  endfunction

  always @(posedge clk_i) begin : check_outputs
    pixel_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("Output word arrived with no pixel outstanding.");
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out);
          mismatches++;
        end
        if (green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out);
          mismatches++;
        end
        if (blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
          mismatches++;
        end
        if (was_marked !== want.marked) begin
          $error("was_marked: expected %0d, got %0d", want.marked, was_marked);
          mismatches++;
        end
        if (embedded_bit !== want.mark_bit) begin
          $error("embedded_bit: expected %0d, got %0d", want.mark_bit, embedded_bit);
          mismatches++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned n = 0;
    while (n < MAX_GAP && $urandom_range(99) < send_idle_pct) n++;
    return n;
  endfunction

  task automatic send_word(input embed_word_t w);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid = 1'b0;
    end
    @(negedge clk_i);
    command = w.command;
    mark_value = w.mark_value;
    pixel_x = w.x;
    pixel_y = w.y;
    red_in = w.red;
    green_in = w.green;
    blue_in = w.blue;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    embed_predict(w);
  endtask

  task automatic send_pixel(input int unsigned x, input int unsigned y,
                            input int unsigned r, input int unsigned g, input int unsigned b);
    embed_word_t w;
    w.command = CMD_PIXEL;
    w.mark_value = COL_W'($urandom_range(255));
    w.x = COORD_W'(x);
    w.y = COORD_W'(y);
    w.red = COL_W'(r);
    w.green = COL_W'(g);
    w.blue = COL_W'(b);
    send_word(w);
  endtask

  task automatic send_load(input int unsigned value);
    embed_word_t w;
    w.command = CMD_LOAD;
    w.mark_value = COL_W'(value);
    w.x = COORD_W'($urandom_range(4095));
    w.y = COORD_W'($urandom_range(4095));
    w.red = COL_W'($urandom_range(255));
    w.green = COL_W'($urandom_range(255));
    w.blue = COL_W'($urandom_range(255));
    send_word(w);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = value;
      CFG_IMAGE_HEIGHT: img_h = value;
      CFG_MARK_WIDTH:   mk_w = value[MSIZE_W-1:0];
      CFG_MARK_HEIGHT:  mk_h = value[MSIZE_W-1:0];
      CFG_ROW_FIRST:    row_lo = value[COORD_W-1:0];
      CFG_ROW_END:      row_hi = value;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned mw,
                           input int unsigned mh, input int unsigned rf, input int unsigned re);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_MARK_WIDTH, CFG_DATA_W'(mw));
    write_reg(CFG_MARK_HEIGHT, CFG_DATA_W'(mh));
    write_reg(CFG_ROW_FIRST, CFG_DATA_W'(rf));
    write_reg(CFG_ROW_END, CFG_DATA_W'(re));
    settings_used++;
  endtask

  function automatic int unsigned pick_size(input int unsigned hi);
    case ($urandom_range(5))
      0: return 1;
      1: return hi;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  function automatic int unsigned pick_coord(input int unsigned span);
    if (span == 0 || $urandom_range(3) == 0) return $urandom_range(4095);
    return $urandom_range((span > MAX_IMAGE_SIDE ? MAX_IMAGE_SIDE : span) - 1);
  endfunction

  function automatic int unsigned pick_row();
    int unsigned top;
    top = (row_hi < img_h) ? row_hi : img_h;
    if (top > row_lo && $urandom_range(1) == 0) return $urandom_range(row_lo, top - 1);
    return pick_coord(img_h);
  endfunction

  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    send_idle_pct = sender;
    stall_pct = receiver;
  endtask

  task automatic send_random_word();
    if ($urandom_range(4) == 0) begin
      send_load($urandom_range(255));
    end else begin
      send_pixel(pick_coord(img_w), pick_row(), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
    end
  endtask

  // Only the first MARK_FILL entries are loaded before random traffic, and every entry read later lies in them.
  // The last four entries are loaded by the corner test.
  task automatic test_store_fill();
    set_idling(0, 0);
    configure(640, 480, 16, 16, 0, 4096);
    send_load(0);
    send_load(128);
    send_load(129);
    send_load(255);
    repeat (MARK_FILL - 8) send_load($urandom_range(255));
    wait_idle();
  endtask

  // Each load fills the entry that the pixel right behind it reads.
  task automatic test_corner_pixels();
    send_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    send_pixel(640, 0, 8'h5A, 8'hA5, 8'h3C);
    send_pixel(0, 480, 8'h81, 8'h7E, 8'h01);
    send_pixel(4095, 4095, 8'hAA, 8'h55, 8'h01);
    send_load(255);
    send_pixel(480, 450, 8'hFE, 8'hFE, 8'hFE);
    send_load(0);
    send_pixel(520, 450, 8'h01, 8'h01, 8'h01);
    send_load(128);
    send_pixel(560, 450, 8'hFF, 8'h01, 8'h80);
    send_load(129);
    send_pixel(600, 450, 8'h00, 8'hFE, 8'h7F);
    send_pixel(639, 479, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
  endtask

  task automatic test_row_window();
    configure(640, 480, 16, 16, 100, 200);
    send_pixel(5, 99, 8'h10, 8'h11, 8'h12);
    send_pixel(5, 100, 8'h10, 8'h11, 8'h12);
    send_pixel(5, 199, 8'h10, 8'h11, 8'h12);
    send_pixel(5, 200, 8'h10, 8'h11, 8'h12);
    configure(640, 480, 16, 16, 300, 300);
    send_pixel(7, 300, 8'h33, 8'h44, 8'h55);
    configure(0, 480, 16, 16, 0, 4096);
    send_pixel(0, 0, 8'h66, 8'h77, 8'h88);
    configure(640, 0, 16, 16, 0, 4096);
    send_pixel(0, 0, 8'h99, 8'hAA, 8'hBB);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    configure(4096, 4096, 1, 1, 4095, 4096);
    send_pixel(4095, 4095, 8'h00, 8'hFF, 8'h00);
    send_pixel(0, 4094, 8'hFF, 8'h00, 8'hFF);
    configure(1, 1, 64, 64, 0, 4096);
    send_pixel(0, 0, 8'h42, 8'h43, 8'h44);
    send_pixel(1, 0, 8'h42, 8'h43, 8'h44);
    configure(4096, 4096, 64, 64, 0, 4096);
    // Writes with bits above the register width are truncated to 127 marks.
    write_reg(CFG_MARK_WIDTH, '1);
    write_reg(CFG_MARK_HEIGHT, '1);
    // Mark row 33 of a 127-wide mark lies past the store depth and wraps to entry 95.
    send_pixel(64, 0, 8'h12, 8'h34, 8'h56);
    send_pixel(0, 1065, 8'h65, 8'h43, 8'h21);
    wait_idle();
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(8191)));
    write_reg(CFG_SPARE_B, '1);
    send_pixel(64, 1065, 8'h12, 8'h34, 8'h56);
    wait_idle();
    write_reg(CFG_ROW_FIRST, '1);
    write_reg(CFG_ROW_END, '0);
    send_pixel(100, 4095, 8'hC3, 8'h3C, 8'hE7);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned pct_sender [4] = '{0, 48, 0, 34};
    int unsigned pct_receiver [4] = '{0, 0, 48, 34};
    int unsigned h, rf, mw, mh;
    for (int p = 0; p < 4; p++) begin
      h = pick_size(MAX_IMAGE_SIDE);
      rf = ($urandom_range(3) == 0) ? 0 : $urandom_range(h - 1);
      mw = pick_size(64);
      mh = pick_size(MARK_FILL / mw);
      configure(pick_size(MAX_IMAGE_SIDE), h, mw, mh, rf,
                ($urandom_range(3) == 0) ? MAX_IMAGE_SIDE : $urandom_range(rf, MAX_IMAGE_SIDE));
      set_idling(pct_sender[p], pct_receiver[p]);
      repeat (PHASE_WORDS / 2) send_random_word();
      wait_drained();
      repeat (PHASE_WORDS - PHASE_WORDS / 2) send_random_word();
    end
    set_idling(0, 0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    configure(640, 480, 16, 16, 0, 4096);
    set_idling(0, 0);
    hold_left = HOLD_CYCLES;
    repeat (80) send_pixel(pick_coord(img_w), pick_coord(img_h), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255));
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < MARK_DEPTH; i++) mark_store[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_store_fill();
    test_corner_pixels();
    test_row_window();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    $display("Checked %0d pixel words with %0d watermark loads over %0d register settings,",
             pixels_checked, loads_sent, settings_used);
    $display("including loads read right behind, the store index wrap, row window edges and a long output hold-off.");
    if (mismatches == 0) begin
      $display("** lsb_watermark_embed: PASSED **");
    end else begin
      $display("** lsb_watermark_embed: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("The run timed out with %0d pixel words outstanding.", expected_pixels.size());
    $display("** lsb_watermark_embed: FAILED **");
    $finish;
  end

endmodule

### sim.f
design/lwe_pkg.sv
design/lwe_mark_ram.sv
design/lwe_scale.sv
design/lsb_watermark_embed.sv
tb/lsb_watermark_embed_test.sv
